@@ rtl/core/sifb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register codes and the CRC-16 byte update for the frame builder.
// No dependencies; every other file of the block refers to this package by scoped names.
package sifb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HEADER_WORD     = 3'd0;
    localparam logic [2:0] CFG_CRC_POLYNOMIAL  = 3'd1;
    localparam logic [2:0] CFG_CRC_SEED        = 3'd2;
    localparam logic [2:0] CFG_MAX_FRAME_BYTES = 3'd3;

    // Register reset values.
    localparam logic [31:0] RST_HEADER_WORD     = 32'h00FD_FFFF;
    localparam logic [15:0] RST_CRC_POLYNOMIAL  = 16'h8005;
    localparam logic [15:0] RST_CRC_SEED        = 16'h0000;
    localparam logic [15:0] RST_MAX_FRAME_BYTES = 16'hFFFF;

    // Input opcodes.
    localparam logic OPCODE_START = 1'b0;
    localparam logic OPCODE_PARAM = 1'b1;

    // Frame layout: id, two length bytes, instruction and two CRC bytes
    // come on top of the header and the parameters.
    localparam int          FRAME_FIXED_BYTES = 6;
    localparam logic [15:0] LEN_FIELD_BIAS    = 16'd3;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        logic [31:0] header_word;
        logic [15:0] crc_polynomial;
        logic [15:0] crc_seed;
        logic [15:0] max_frame_bytes;
    } t_cfg;

    // One input item.
    typedef struct packed {
        logic        opcode;
        logic [7:0]  device_id;
        logic [7:0]  instruction_code;
        logic [15:0] param_count;
        logic [7:0]  param_byte;
    } t_item;

    // Sequencer status toward the top level.
    typedef struct packed {
        logic item_busy;
        logic frame_open;
    } t_seq_status;

    // MSB-first CRC-16 update over one byte, no reflection.
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [15:0] poly,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ rtl/core/sifb_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the frame builder: four registers written by index.
// Depends on sifb_pkg for the register codes, reset values and the t_cfg struct.
module sifb_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output sifb_pkg::t_cfg      o_cfg
);

    sifb_pkg::t_cfg r_cfg;

    // Writes are taken in every cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register update; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_word     <= sifb_pkg::RST_HEADER_WORD;
            r_cfg.crc_polynomial  <= sifb_pkg::RST_CRC_POLYNOMIAL;
            r_cfg.crc_seed        <= sifb_pkg::RST_CRC_SEED;
            r_cfg.max_frame_bytes <= sifb_pkg::RST_MAX_FRAME_BYTES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sifb_pkg::CFG_HEADER_WORD:     r_cfg.header_word     <= i_cfg_data;
                sifb_pkg::CFG_CRC_POLYNOMIAL:  r_cfg.crc_polynomial  <= i_cfg_data[15:0];
                sifb_pkg::CFG_CRC_SEED:        r_cfg.crc_seed        <= i_cfg_data[15:0];
                sifb_pkg::CFG_MAX_FRAME_BYTES: r_cfg.max_frame_bytes <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ rtl/core/sifb_frame_seq.sv @@
`timescale 1ns / 1ps
// Frame sequencer: item register, byte sequencer with running CRC, and output register.
// Depends on sifb_pkg for the item and configuration structs and the CRC update.
module sifb_frame_seq #(
    parameter int HEADER_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sifb_pkg::t_cfg        i_cfg,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  sifb_pkg::t_item       i_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_eof,
    output logic                  o_out_status,
    output sifb_pkg::t_seq_status o_status
);

    localparam int HdrIdxW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam logic [HdrIdxW-1:0] HdrLast = HdrIdxW'(HEADER_BYTES - 1);
    localparam logic [16:0] Overhead = 17'(HEADER_BYTES + sifb_pkg::FRAME_FIXED_BYTES);

    typedef enum logic [2:0] {
        P_HDR,
        P_ID,
        P_LEN_LO,
        P_LEN_HI,
        P_INSTR,
        P_PARAM,
        P_CRC_LO,
        P_CRC_HI
    } t_phase;

    // Item register and sequencer state.
    sifb_pkg::t_item   r_item;
    logic              r_item_valid;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [HdrIdxW-1:0] r_hdr_idx;
    logic [HdrIdxW-1:0] n_hdr_idx;
    logic [15:0]       r_crc;
    logic [15:0]       n_crc;
    logic [15:0]       r_remaining;
    logic [15:0]       n_remaining;
    logic              r_open;
    logic              n_open;

    // Output register.
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_eof;
    logic              r_out_status;
    logic [7:0]        n_byte;
    logic              n_eof;
    logic              n_status;

    logic              w_slot;
    logic              w_emit;
    logic              w_done;
    logic              w_crc_en;
    logic              w_accept;
    logic              w_too_long;
    logic [16:0]       w_frame_size;
    logic [15:0]       w_len_field;
    logic [15:0]       w_crc_base;

    assign w_slot       = !r_out_valid || i_out_ready;
    assign w_frame_size = {1'b0, r_item.param_count} + Overhead;
    // Covers both the 16-bit length overflow and the receiver limit.
    assign w_too_long   = w_frame_size > {1'b0, i_cfg.max_frame_bytes};
    assign w_len_field  = r_item.param_count + sifb_pkg::LEN_FIELD_BIAS;
    assign w_crc_base   = (r_phase == P_HDR && r_hdr_idx == '0) ? i_cfg.crc_seed : r_crc;

    // One byte per cycle when the output register has room.
    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_remaining = r_remaining;
        n_open      = r_open;
        n_byte      = 8'h00;
        n_eof       = 1'b0;
        n_status    = 1'b0;
        w_emit      = 1'b0;
        w_done      = 1'b0;
        w_crc_en    = 1'b0;
        if (r_item_valid) begin
            unique case (r_phase)
                P_HDR: begin
                    if (w_slot) begin
                        w_emit = 1'b1;
                        if (r_hdr_idx == '0) begin
                            n_open      = 1'b0;
                            n_remaining = '0;
                        end
                        if (r_hdr_idx == '0 && w_too_long) begin
                            n_eof    = 1'b1;
                            n_status = 1'b1;
                            w_done   = 1'b1;
                        end else begin
                            n_byte   = i_cfg.header_word[8*r_hdr_idx +: 8];
                            w_crc_en = 1'b1;
                            if (r_hdr_idx == HdrLast) begin
                                n_phase = P_ID;
                            end else begin
                                n_hdr_idx = r_hdr_idx + 1'b1;
                            end
                        end
                    end
                end
                P_ID: begin
                    if (w_slot) begin
                        w_emit   = 1'b1;
                        w_crc_en = 1'b1;
                        n_byte   = r_item.device_id;
                        n_phase  = P_LEN_LO;
                    end
                end
                P_LEN_LO: begin
                    if (w_slot) begin
                        w_emit   = 1'b1;
                        w_crc_en = 1'b1;
                        n_byte   = w_len_field[7:0];
                        n_phase  = P_LEN_HI;
                    end
                end
                P_LEN_HI: begin
                    if (w_slot) begin
                        w_emit   = 1'b1;
                        w_crc_en = 1'b1;
                        n_byte   = w_len_field[15:8];
                        n_phase  = P_INSTR;
                    end
                end
                P_INSTR: begin
                    if (w_slot) begin
                        w_emit   = 1'b1;
                        w_crc_en = 1'b1;
                        n_byte   = r_item.instruction_code;
                        if (r_item.param_count == '0) begin
                            n_phase = P_CRC_LO;
                        end else begin
                            n_remaining = r_item.param_count;
                            n_open      = 1'b1;
                            w_done      = 1'b1;
                        end
                    end
                end
                P_PARAM: begin
                    if (!r_open) begin
                        // Parameter without an open frame is dropped.
                        w_done = 1'b1;
                    end else if (w_slot) begin
                        w_emit      = 1'b1;
                        w_crc_en    = 1'b1;
                        n_byte      = r_item.param_byte;
                        n_remaining = r_remaining - 1'b1;
                        if (r_remaining == 16'd1) begin
                            n_phase = P_CRC_LO;
                        end else begin
                            w_done = 1'b1;
                        end
                    end
                end
                P_CRC_LO: begin
                    if (w_slot) begin
                        w_emit  = 1'b1;
                        n_byte  = r_crc[7:0];
                        n_phase = P_CRC_HI;
                    end
                end
                P_CRC_HI: begin
                    if (w_slot) begin
                        w_emit = 1'b1;
                        n_byte = r_crc[15:8];
                        n_eof  = 1'b1;
                        n_open = 1'b0;
                        w_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        n_crc = w_crc_en ? sifb_pkg::crc_update(w_crc_base, i_cfg.crc_polynomial, n_byte)
                         : r_crc;
    end

    // A new item enters as soon as the held one finishes.
    assign o_item_ready = !r_item_valid || w_done;
    assign w_accept     = i_item_valid && o_item_ready;

    // State and output register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (w_emit) begin
            r_out_byte   <= n_byte;
            r_out_eof    <= n_eof;
            r_out_status <= n_status;
        end
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_phase      <= P_HDR;
            r_hdr_idx    <= '0;
            r_crc        <= '0;
            r_remaining  <= '0;
            r_open       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_item_valid <= 1'b1;
                r_phase      <= (i_item.opcode == sifb_pkg::OPCODE_PARAM) ? P_PARAM : P_HDR;
                r_hdr_idx    <= '0;
            end else begin
                if (w_done) begin
                    r_item_valid <= 1'b0;
                end
                r_phase   <= n_phase;
                r_hdr_idx <= n_hdr_idx;
            end
            r_crc       <= n_crc;
            r_remaining <= n_remaining;
            r_open      <= n_open;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_byte          = r_out_byte;
    assign o_out_eof           = r_out_eof;
    assign o_out_status        = r_out_status;
    assign o_status.item_busy  = r_item_valid;
    assign o_status.frame_open = r_open;

endmodule

@@ rtl/core/servo_instruction_frame_builder.sv @@
`timescale 1ns / 1ps
// Top level of the servo instruction frame builder: stream ports, configuration port, checks.
// Depends on sifb_pkg, sifb_cfg_regs and sifb_frame_seq.

// A start transaction (tuser 0) produces HEADER_BYTES header bytes, the device id, the
// little-endian length (count plus 3) and the instruction, then the two CRC bytes at once
// if the count is zero; each parameter transaction (tuser 1) passes one byte through, and
// the last one of a frame is followed by the CRC, low byte first, with tlast on the high
// byte. The sequencer writes one byte per cycle into the output register while the
// output register has room. An over-long or overflowing frame gives a single
// transaction with data 0, tlast 1 and tuser 1, and opens no frame. A parameter with no
// frame open is consumed without output. Input ready depends combinationally on output
// ready; configuration writes are taken in every cycle.
module servo_instruction_frame_builder #(
    parameter int HEADER_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // From bit 0: device_id[7:0], instruction_code[15:8], param_count[31:16],
    // param_byte[39:32].
    input  logic [39:0] i_s_tdata,
    // Bit 0: opcode.
    input  logic [0:0]  i_s_tuser,
    // Frame byte stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Bits 7:0: frame_byte.
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    // Bit 0: status.
    output logic [0:0]  o_m_tuser,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    sifb_pkg::t_cfg        w_cfg;
    sifb_pkg::t_item       w_item;
    sifb_pkg::t_seq_status w_status;

    // Unpack the input transaction.
    assign w_item.opcode           = i_s_tuser[0];
    assign w_item.device_id        = i_s_tdata[7:0];
    assign w_item.instruction_code = i_s_tdata[15:8];
    assign w_item.param_count      = i_s_tdata[31:16];
    assign w_item.param_byte       = i_s_tdata[39:32];

    sifb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sifb_frame_seq #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_frame_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (i_s_tvalid),
        .o_item_ready (o_s_tready),
        .i_item       (w_item),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_byte   (o_m_tdata),
        .o_out_eof    (o_m_tlast),
        .o_out_status (o_m_tuser[0]),
        .o_status     (w_status)
    );

    // An error transaction always closes the frame.
    a_error_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("error transaction without tlast");

    // An error transaction carries a zero data byte.
    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 8'h00))
        else $error("error transaction with nonzero data");

    // With the output stalled, a new item is taken only into an empty item register or while no frame is open.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready && o_s_tready) |-> !w_status.item_busy
            || (w_status.item_busy && !w_status.frame_open))
        else $error("input accepted while busy item waits on a stalled output");

endmodule
